FILE: rtl/lspt_pkg.sv
// Package with the request and result types and the constants of the line sensor tracker.
package lspt_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int THRESH_W        = 12;
  localparam int FRAC_BITS       = 14;
  localparam int QUO_W           = 15;
  localparam int ERR_W           = 16;
  localparam int OFF_W           = 4;
  localparam int OFF_MAX         = 7;
  localparam int Q_ONE           = 16384;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd2048;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [2:0]  channel;
    logic [11:0] raw_sample;
  } in_t;

  typedef struct packed {
    logic [11:0]        filtered_value;
    logic               line_found;
    logic signed [3:0]  edge_offset;
    logic signed [15:0] line_error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_OFFSET,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/lspt_level_store.sv
// Filtered level memory with a registered read port and per-entry valid bits cleared at reset.
module lspt_level_store #(
  parameter int CHANNELS    = lspt_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = lspt_pkg::SAMPLE_BITS_DEF,
  localparam int AW         = $clog2(CHANNELS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data
);

  logic [SAMPLE_BITS-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]    valid_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/lspt_err_div.sv
// Three-stage divider of the offset magnitude scaled to unsigned Q1.14 by the constant CHANNELS-1.
module lspt_err_div #(
  parameter int CHANNELS = lspt_pkg::CHANNELS_DEF,
  localparam int AW      = $clog2(CHANNELS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [AW-1:0]              magnitude,
  output logic                       done,
  output logic [lspt_pkg::QUO_W-1:0] quotient
);

  localparam int QW    = lspt_pkg::QUO_W;
  localparam int K     = AW + lspt_pkg::FRAC_BITS;
  localparam int DIV   = CHANNELS - 1;
  localparam int RECIP = (2 ** K) / DIV;
  localparam int RW    = AW + QW + 1;
  localparam logic [K:0]    RECIP_V = (K+1)'(RECIP);
  localparam logic [AW-1:0] DIV_V   = AW'(DIV);

  logic          v1_r, v2_r, v3_r;
  logic [AW-1:0] mag1_r, mag2_r;
  logic [AW+K:0] prod_r;
  logic [QW-1:0] q0_r, q_r;
  logic [QW+AW-1:0] qd_r;
  logic [QW-1:0] q0;
  logic [RW-1:0] rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign q0  = QW'(prod_r >> AW);
  assign rem = RW'({mag2_r, {lspt_pkg::FRAC_BITS{1'b0}}}) - RW'(qd_r);

  always_ff @(posedge clk) begin
    mag1_r <= magnitude;
    prod_r <= (AW+K+1)'(magnitude) * (AW+K+1)'(RECIP_V);
    mag2_r <= mag1_r;
    q0_r   <= q0;
    qd_r   <= (QW+AW)'(q0) * (QW+AW)'(DIV_V);
    q_r    <= (rem >= RW'(DIV_V)) ? q0_r + QW'(1) : q0_r;
  end

  assign done     = v3_r;
  assign quotient = q_r;

endmodule

FILE: rtl/line_sensor_position_tracker.sv
// Top level of the line sensor tracker: request sequencer, threshold register and result register.
// A sample request goes from acceptance to a loaded result through one memory read, one
// read-modify-write of the filtered level and the load of the output register. A query runs
// the scan that reads one stored level per cycle through the single read port of the level
// memory, then the offset state, the three-stage divider when a line was found, and the
// result load.
// A new request is accepted as soon as the previous result sits in the output register.
module line_sensor_position_tracker #(
  parameter int CHANNELS    = lspt_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = lspt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lspt_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lspt_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lspt_pkg::THRESH_W-1:0]     cfg_data
);

  localparam int AW = $clog2(CHANNELS);
  localparam int OW = AW + 2;
  localparam int SB = SAMPLE_BITS;
  localparam int QW = lspt_pkg::QUO_W;
  localparam int EW = lspt_pkg::ERR_W;

  lspt_pkg::state_t state_r, state_nxt;
  lspt_pkg::in_t    req_r;
  lspt_pkg::out_t   res_r, out_data_r;
  logic             out_valid_r;
  logic [lspt_pkg::THRESH_W-1:0] thresh_r;
  logic signed [EW-1:0] held_err_r;
  logic signed [lspt_pkg::OFF_W-1:0] held_off_r;

  logic [AW-1:0] scan_idx_r, left_r, right_r;
  logic          found_r;
  logic signed [OW-1:0] off_r;

  logic          accept, out_load, chan_ok, hit, scan_last;
  logic          rd_en, wr_en, div_start, div_done;
  logic [AW-1:0] rd_addr, chan_addr, div_mag;
  logic [SB-1:0] rd_data, new_level, raw_ext;
  logic [SB+1:0] level_sum;
  logic [15:0]   raw16;
  logic [QW-1:0] div_q, q_clamped;
  logic signed [OW-1:0] off_now;
  logic signed [7:0]    off_wide;
  logic signed [lspt_pkg::OFF_W-1:0] off_sat;
  logic signed [EW-1:0] err_val;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign out_load  = (state_r == lspt_pkg::ST_RESULT) & (~out_valid_r | out_ready);
  assign chan_ok   = {29'd0, in_data.channel} < 32'(CHANNELS);
  assign chan_addr = AW'(in_data.channel);

  assign raw16     = 16'(req_r.raw_sample);
  assign raw_ext   = raw16[SB-1:0];
  assign level_sum = (SB+2)'({rd_data, 1'b0}) + (SB+2)'(rd_data) + (SB+2)'(raw_ext);
  assign new_level = level_sum[SB+1:2];

  assign hit       = 17'(rd_data) > 17'(thresh_r);
  assign scan_last = scan_idx_r == AW'(CHANNELS - 1);

  assign off_now   = OW'(left_r) + OW'(right_r) - OW'(CHANNELS - 1);
  assign div_mag   = AW'((off_now < 0) ? -off_now : off_now);
  assign off_wide  = 8'(off_r);
  assign off_sat   = (off_wide > 8'sd7) ? 4'(lspt_pkg::OFF_MAX) :
                     (off_wide < -8'sd7) ? -4'(lspt_pkg::OFF_MAX) : 4'(off_wide);
  assign q_clamped = (div_q > QW'(lspt_pkg::Q_ONE)) ? QW'(lspt_pkg::Q_ONE) : div_q;
  assign err_val   = (off_r < 0) ? -EW'(q_clamped) : EW'(q_clamped);

  lspt_level_store #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(AW'(req_r.channel)),
    .wr_data(new_level)
  );

  lspt_err_div #(
    .CHANNELS(CHANNELS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .magnitude(div_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lspt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command == lspt_pkg::CMD_QUERY) begin
            state_nxt = lspt_pkg::ST_SCAN;
          end else if (chan_ok) begin
            state_nxt = lspt_pkg::ST_UPDATE;
          end else begin
            state_nxt = lspt_pkg::ST_RESULT;
          end
        end
      end
      lspt_pkg::ST_UPDATE: state_nxt = lspt_pkg::ST_RESULT;
      lspt_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = lspt_pkg::ST_OFFSET;
        end
      end
      lspt_pkg::ST_OFFSET: begin
        state_nxt = found_r ? lspt_pkg::ST_DIVIDE : lspt_pkg::ST_RESULT;
      end
      lspt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = lspt_pkg::ST_RESULT;
        end
      end
      lspt_pkg::ST_RESULT: begin
        if (~out_valid_r | out_ready) begin
          state_nxt = lspt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lspt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    case (state_r)
      lspt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.command == lspt_pkg::CMD_QUERY) begin
            rd_en = 1'b1;
          end else if (chan_ok) begin
            rd_en   = 1'b1;
            rd_addr = chan_addr;
          end
        end
      end
      lspt_pkg::ST_UPDATE: wr_en = 1'b1;
      lspt_pkg::ST_SCAN: begin
        if (!scan_last) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx_r + AW'(1);
        end
      end
      lspt_pkg::ST_OFFSET: div_start = found_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lspt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      thresh_r    <= lspt_pkg::THRESH_RESET;
      held_err_r  <= '0;
      held_off_r  <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid & cfg_ready) begin
        thresh_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        found_r <= 1'b0;
      end else if ((state_r == lspt_pkg::ST_SCAN) && hit) begin
        found_r <= 1'b1;
      end
      if ((state_r == lspt_pkg::ST_DIVIDE) && div_done) begin
        held_err_r <= err_val;
        held_off_r <= off_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_data;
      scan_idx_r <= '0;
      res_r      <= '0;
    end
    case (state_r)
      lspt_pkg::ST_UPDATE: res_r.filtered_value <= 12'(new_level);
      lspt_pkg::ST_SCAN: begin
        scan_idx_r <= scan_idx_r + AW'(1);
        if (hit) begin
          if (!found_r) begin
            left_r <= scan_idx_r;
          end
          right_r <= scan_idx_r;
        end
      end
      lspt_pkg::ST_OFFSET: begin
        off_r                <= off_now;
        res_r.line_found     <= 1'b0;
        res_r.edge_offset    <= held_off_r;
        res_r.line_error     <= held_err_r;
      end
      lspt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          res_r.line_found  <= 1'b1;
          res_r.edge_offset <= off_sat;
          res_r.line_error  <= err_val;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> ##3 div_done)
    else $error("Divider did not finish three cycles after start.");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.line_error <= 16'sd16384) && (out_data.line_error >= -16'sd16384))
    else $error("Line error outside of plus or minus one.");

  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.line_found) |->
      ((out_data.edge_offset < 0) == (out_data.line_error < 0)) &&
      ((out_data.edge_offset == 0) == (out_data.line_error == 0)))
    else $error("Offset and error disagree in sign.");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.filtered_value != 12'd0)) |->
      (!out_data.line_found && (out_data.edge_offset == 4'sd0) &&
       (out_data.line_error == 16'sd0)))
    else $error("Sample result carries query fields.");

endmodule

FILE: tb/line_sensor_position_tracker_test.sv
// Self-checking testbench for the line sensor tracker: directed table, then random phases.
module line_sensor_position_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH = lspt_pkg::CHANNELS_DEF;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_ROWS = 25;

  typedef struct packed {
    lspt_pkg::in_t  req;
    logic           typed;
    lspt_pkg::out_t result;
  } step_t;

  localparam lspt_pkg::out_t NO_RESULT = '0;

  localparam step_t DIRECTED [NUM_ROWS] = '{
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b1, '{12'd0, 1'b0, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd0, 12'h000}, 1'b1, '{12'd0, 1'b0, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd7, 12'hFFF}, 1'b1, '{12'd1023, 1'b0, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd7, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd7, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b1, '{12'd0, 1'b1, 4'sd7, 16'sd16384}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd0, 12'hFFF}, 1'b1, '{12'd1023, 1'b0, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd0, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd0, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b1, '{12'd0, 1'b1, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd3, 12'hFFF}, 1'b1, '{12'd1023, 1'b0, 4'sd0, 16'sd0}},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd7, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd7, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd0, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd7, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd3, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd3, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd4, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd4, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd4, 12'hFFF}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd0, 12'h000}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_SAMPLE, 3'd5, 12'hAAA}, 1'b0, NO_RESULT},
    '{'{lspt_pkg::CMD_QUERY,  3'd2, 12'h555}, 1'b0, NO_RESULT}
  };

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  lspt_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  lspt_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [11:0]    cfg_data;

  logic [11:0]        level_mem [NUM_CH];
  logic [11:0]        line_threshold_q;
  logic signed [15:0] held_err;
  logic signed [3:0]  held_off;
  lspt_pkg::out_t     pending_results [$];
  int                 mismatch_count;
  int                 line_pos;
  bit                 idle_en;

  line_sensor_position_tracker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic lspt_pkg::out_t track_position(input lspt_pkg::in_t req);
    lspt_pkg::out_t r;
    int   lo;
    int   hi;
    int   off;
    int   err;
    r = '0;
    if (req.command == lspt_pkg::CMD_SAMPLE) begin
      if (int'(req.channel) < NUM_CH) begin
        level_mem[req.channel] =
          12'((32'(level_mem[req.channel]) * 3 + 32'(req.raw_sample)) / 4);
        r.filtered_value = level_mem[req.channel];
      end
    end else begin
      lo = -1;
      hi = -1;
      for (int i = 0; i < NUM_CH; i++) begin
        if (level_mem[i] > line_threshold_q) begin
          if (lo < 0) lo = i;
          hi = i;
        end
      end
      if (lo >= 0) begin
        off = lo + hi - (NUM_CH - 1);
        err = (off * lspt_pkg::Q_ONE) / (NUM_CH - 1);
        if (err > lspt_pkg::Q_ONE) err = lspt_pkg::Q_ONE;
        if (err < -lspt_pkg::Q_ONE) err = -lspt_pkg::Q_ONE;
        if (off > lspt_pkg::OFF_MAX) off = lspt_pkg::OFF_MAX;
        if (off < -lspt_pkg::OFF_MAX) off = -lspt_pkg::OFF_MAX;
        held_err = 16'(err);
        held_off = 4'(off);
        r.line_found = 1'b1;
      end
      r.edge_offset = held_off;
      r.line_error  = held_err;
    end
    return r;
  endfunction

  // Most samples paint a band of three channels around a moving line position.
  function automatic lspt_pkg::in_t random_request();
    lspt_pkg::in_t r;
    int  span;
    if ($urandom_range(0, 19) == 0) line_pos = $urandom_range(0, NUM_CH - 1);
    r.command = ($urandom_range(0, 4) == 0) ? lspt_pkg::CMD_QUERY : lspt_pkg::CMD_SAMPLE;
    r.channel = 3'($urandom_range(0, 7));
    span = int'(r.channel) - line_pos;
    if ($urandom_range(0, 9) < 7) begin
      if (span >= -1 && span <= 1) r.raw_sample = 12'($urandom_range(3000, 4095));
      else r.raw_sample = 12'($urandom_range(0, 800));
    end else begin
      r.raw_sample = 12'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input lspt_pkg::in_t req, input logic typed,
                              input lspt_pkg::out_t result);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      void'(track_position(req));
      pending_results.push_back(result);
    end else begin
      pending_results.push_back(track_position(req));
    end
  endtask

  task automatic set_threshold(input logic [11:0] level);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_threshold_q = level;
  endtask

  initial begin
    int             stall_left;
    lspt_pkg::out_t exp_res;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %h", out_data);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data.filtered_value !== exp_res.filtered_value) begin
            $error("filtered_value: expected %0d, got %0d",
                   exp_res.filtered_value, out_data.filtered_value);
            mismatch_count++;
          end
          if (out_data.line_found !== exp_res.line_found) begin
            $error("line_found: expected %0d, got %0d",
                   exp_res.line_found, out_data.line_found);
            mismatch_count++;
          end
          if (out_data.edge_offset !== exp_res.edge_offset) begin
            $error("edge_offset: expected %0d, got %0d",
                   exp_res.edge_offset, out_data.edge_offset);
            mismatch_count++;
          end
          if (out_data.line_error !== exp_res.line_error) begin
            $error("line_error: expected %0d, got %0d",
                   exp_res.line_error, out_data.line_error);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [11:0] thresh_plan [PHASES];
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    mismatch_count = 0;
    idle_en  = 1'b1;
    line_pos = 3;
    line_threshold_q = lspt_pkg::THRESH_RESET;
    held_err = '0;
    held_off = '0;
    foreach (level_mem[i]) level_mem[i] = '0;
    thresh_plan = '{12'd0, 12'd4095, 12'($urandom), 12'd1500, 12'($urandom), 12'd2048};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NUM_ROWS; k++) begin
      send_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].result);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      set_threshold(thresh_plan[p]);
      if (p == PHASES - 1) idle_en = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(random_request(), 1'b0, NO_RESULT);
      end
      in_valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lspt_pkg.sv
rtl/lspt_level_store.sv
rtl/lspt_err_div.sv
rtl/line_sensor_position_tracker.sv
tb/line_sensor_position_tracker_test.sv
